FILE: rtl/core/srsp_pkg.sv
// shared types and constants of the shard range segment planner
package srsp_pkg;

  localparam int unsigned MaxBatch = 65536;
  localparam int unsigned BoffW    = $clog2(MaxBatch + 1);

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_SAMPLE = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    KIND_ACK = 2'd0,
    KIND_SEG = 2'd1,
    KIND_ERR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_OK      = 3'd0,
    ERR_RANGE   = 3'd1,
    ERR_GAP     = 3'd2,
    ERR_TABLE   = 3'd3,
    ERR_TOOLONG = 3'd4
  } err_e;

  typedef struct packed {
    logic latch;
    logic table_op;
    logic chk;
    logic srch_rd;
    logic srch_cmp;
    logic end_rd;
    logic end_cmp;
    logic merge;
    logic final_emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_req;
    logic       out_free;
    logic       skip;
    logic       srch_done;
    logic       lo_zero;
    logic       merge_emit;
    logic       last;
  } sts_t;

endpackage

FILE: rtl/core/srsp_ctrl.sv
// controller state machine of the shard range segment planner
module srsp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  srsp_pkg::sts_t sts_i,
  output srsp_pkg::cmd_t cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_TABLE    = 9'b000000010,
    ST_CHK      = 9'b000000100,
    ST_SRCH_RD  = 9'b000001000,
    ST_SRCH_CMP = 9'b000010000,
    ST_END_RD   = 9'b000100000,
    ST_END_CMP  = 9'b001000000,
    ST_MERGE    = 9'b010000000,
    ST_FINAL    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          case (sts_i.in_req)
            srsp_pkg::REQ_CLEAR, srsp_pkg::REQ_APPEND: state_d = ST_TABLE;
            srsp_pkg::REQ_SAMPLE: state_d = ST_CHK;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_TABLE: begin
        if (sts_i.out_free) begin
          cmd_o.table_op = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_CHK: begin
        cmd_o.chk = 1'b1;
        state_d   = ST_SRCH_RD;
      end
      ST_SRCH_RD: begin
        if (sts_i.skip) begin
          state_d = ST_MERGE;
        end else if (sts_i.srch_done) begin
          state_d = ST_END_RD;
        end else begin
          cmd_o.srch_rd = 1'b1;
          state_d = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: begin
        cmd_o.srch_cmp = 1'b1;
        state_d = ST_SRCH_RD;
      end
      ST_END_RD: begin
        cmd_o.end_rd = 1'b1;
        state_d = sts_i.lo_zero ? ST_MERGE : ST_END_CMP;
      end
      ST_END_CMP: begin
        cmd_o.end_cmp = 1'b1;
        state_d = ST_MERGE;
      end
      ST_MERGE: begin
        if (!sts_i.merge_emit || sts_i.out_free) begin
          cmd_o.merge = 1'b1;
          state_d = sts_i.last ? ST_FINAL : ST_IDLE;
        end
      end
      ST_FINAL: begin
        if (sts_i.out_free) begin
          cmd_o.final_emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/srsp_datapath.sv
// datapath of the shard range segment planner: range table, search, segment merge
module srsp_datapath #(
  parameter int unsigned MaxShards = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  input  logic [31:0]    cfg_data_i,
  input  logic [1:0]     in_req_i,
  input  logic [191:0]   in_data_i,
  input  logic           in_last_i,
  input  srsp_pkg::cmd_t cmd_i,
  output srsp_pkg::sts_t sts_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     out_kind_o,
  output logic [215:0]   out_data_o,
  output logic           out_done_o
);

  localparam int unsigned CW = $clog2(MaxShards + 1);
  localparam int unsigned AW = (MaxShards > 1) ? $clog2(MaxShards) : 1;
  localparam int unsigned BW = srsp_pkg::BoffW;

  typedef struct packed {
    logic [31:0] sid;
    logic [31:0] first;
    logic [31:0] count;
  } entry_t;

  entry_t mem [MaxShards];
  entry_t rd_q;

  logic [31:0] total_q;
  logic [1:0]  req_q;
  logic [31:0] sid_q, rfirst_q, rcount_q, id_q, tag_q, ord_q;
  logic        last_q;

  logic [CW-1:0] loaded_q, lo_q, hi_q;
  logic [32:0]   exp_q;
  logic          bad_q;

  logic          open_v_q;
  logic [31:0]   open_shard_q, open_first_q, open_last_q;
  logic [15:0]   open_start_q;
  logic [16:0]   open_len_q;
  logic [BW-1:0] boff_q, cnt_q;
  logic [15:0]   off_q;
  logic [2:0]    berr_q, err_q;
  logic [31:0]   shard_q;

  logic          ov_q, od_q;
  logic [1:0]    ok_q;
  logic [2:0]    oe_q;
  logic [31:0]   os_q, of_q, ol_q, ot_q, oo_q;
  logic [15:0]   ost_q;
  logic [16:0]   olen_q, ocnt_q;

  logic [CW-1:0] mid, lo_m1;
  logic          out_free, app_ok, new_bad;
  logic [2:0]    pre_err;
  logic [32:0]   rng_end;

  assign mid      = lo_q + ((hi_q - lo_q) >> 1);
  assign lo_m1    = lo_q - 1'b1;
  assign out_free = !ov_q || out_ready_i;
  assign rng_end  = {1'b0, rd_q.first} + {1'b0, rd_q.count};
  assign app_ok   = !bad_q && (loaded_q < CW'(MaxShards)) && (rcount_q != '0) &&
                    ({1'b0, rfirst_q} == exp_q);
  assign new_bad  = bad_q || !app_ok;

  always_comb begin
    if (boff_q >= BW'(srsp_pkg::MaxBatch)) begin
      pre_err = srsp_pkg::ERR_TOOLONG;
    end else if (bad_q || exp_q != {1'b0, total_q}) begin
      pre_err = srsp_pkg::ERR_TABLE;
    end else if (id_q >= total_q) begin
      pre_err = srsp_pkg::ERR_RANGE;
    end else begin
      pre_err = srsp_pkg::ERR_OK;
    end
  end

  assign sts_o.in_req     = in_req_i;
  assign sts_o.out_free   = out_free;
  assign sts_o.skip       = (berr_q != srsp_pkg::ERR_OK) || (err_q != srsp_pkg::ERR_OK);
  assign sts_o.srch_done  = (lo_q >= hi_q);
  assign sts_o.lo_zero    = (lo_q == '0);
  assign sts_o.merge_emit = (berr_q == srsp_pkg::ERR_OK) && (err_q == srsp_pkg::ERR_OK) &&
                            open_v_q && (open_shard_q != shard_q);
  assign sts_o.last       = last_q;

  // range table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.table_op && req_q == srsp_pkg::REQ_APPEND && app_ok) begin
      mem[loaded_q[AW-1:0]] <= '{sid: sid_q, first: rfirst_q, count: rcount_q};
    end
    if (cmd_i.srch_rd) begin
      rd_q <= mem[mid[AW-1:0]];
    end else if (cmd_i.end_rd && lo_q != '0) begin
      rd_q <= mem[lo_m1[AW-1:0]];
    end
  end

  // latched item and per-sample scratch
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q    <= in_req_i;
      sid_q    <= in_data_i[31:0];
      rfirst_q <= in_data_i[63:32];
      rcount_q <= in_data_i[95:64];
      id_q     <= in_data_i[127:96];
      tag_q    <= in_data_i[159:128];
      ord_q    <= in_data_i[191:160];
      last_q   <= in_last_i;
    end
    if (cmd_i.chk) begin
      off_q <= boff_q[15:0];
      cnt_q <= (boff_q < BW'(srsp_pkg::MaxBatch)) ? boff_q + 1'b1
                                                  : BW'(srsp_pkg::MaxBatch);
      err_q <= (berr_q == srsp_pkg::ERR_OK) ? pre_err : srsp_pkg::ERR_OK;
      lo_q  <= '0;
      hi_q  <= loaded_q;
    end
    if (cmd_i.srch_cmp) begin
      if (id_q < rd_q.first) begin
        hi_q <= mid;
      end else begin
        lo_q <= mid + 1'b1;
      end
    end
    if (cmd_i.end_rd && lo_q == '0) begin
      err_q <= srsp_pkg::ERR_GAP;
    end
    if (cmd_i.end_cmp) begin
      if ({1'b0, id_q} >= rng_end) begin
        err_q <= srsp_pkg::ERR_GAP;
      end
      shard_q <= rd_q.sid;
    end
  end

  // table and batch state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q      <= '0;
      loaded_q     <= '0;
      exp_q        <= '0;
      bad_q        <= 1'b0;
      open_v_q     <= 1'b0;
      open_shard_q <= '0;
      open_start_q <= '0;
      open_len_q   <= '0;
      open_first_q <= '0;
      open_last_q  <= '0;
      boff_q       <= '0;
      berr_q       <= srsp_pkg::ERR_OK;
    end else begin
      if (cfg_valid_i) begin
        total_q <= cfg_data_i;
      end
      if (cmd_i.table_op) begin
        if (req_q == srsp_pkg::REQ_CLEAR) begin
          loaded_q <= '0;
          exp_q    <= '0;
          bad_q    <= 1'b0;
        end else if (app_ok) begin
          loaded_q <= loaded_q + 1'b1;
          exp_q    <= exp_q + {1'b0, rcount_q};
        end else begin
          bad_q <= 1'b1;
        end
      end
      if (cmd_i.chk && boff_q < BW'(srsp_pkg::MaxBatch)) begin
        boff_q <= boff_q + 1'b1;
      end
      if (cmd_i.merge && berr_q == srsp_pkg::ERR_OK) begin
        if (err_q != srsp_pkg::ERR_OK) begin
          berr_q   <= err_q;
          open_v_q <= 1'b0;
        end else if (open_v_q && open_shard_q == shard_q) begin
          open_len_q  <= open_len_q + 1'b1;
          open_last_q <= id_q;
        end else begin
          open_v_q     <= 1'b1;
          open_shard_q <= shard_q;
          open_start_q <= off_q;
          open_len_q   <= 17'd1;
          open_first_q <= id_q;
          open_last_q  <= id_q;
        end
      end
      if (cmd_i.final_emit) begin
        open_v_q     <= 1'b0;
        open_shard_q <= '0;
        open_start_q <= '0;
        open_len_q   <= '0;
        open_first_q <= '0;
        open_last_q  <= '0;
        boff_q       <= '0;
        berr_q       <= srsp_pkg::ERR_OK;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.table_op || cmd_i.final_emit ||
                 (cmd_i.merge && sts_o.merge_emit)) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.table_op) begin
      ok_q   <= srsp_pkg::KIND_ACK;
      oe_q   <= (req_q == srsp_pkg::REQ_APPEND && new_bad) ? srsp_pkg::ERR_TABLE
                                                           : srsp_pkg::ERR_OK;
      os_q   <= '0;
      ost_q  <= '0;
      olen_q <= '0;
      of_q   <= '0;
      ol_q   <= '0;
      ot_q   <= '0;
      oo_q   <= '0;
      ocnt_q <= '0;
      od_q   <= 1'b0;
    end else if (cmd_i.merge && sts_o.merge_emit) begin
      // the segment being closed, before the new one opens
      ok_q   <= srsp_pkg::KIND_SEG;
      oe_q   <= srsp_pkg::ERR_OK;
      os_q   <= open_shard_q;
      ost_q  <= open_start_q;
      olen_q <= open_len_q;
      of_q   <= open_first_q;
      ol_q   <= open_last_q;
      ot_q   <= tag_q;
      oo_q   <= ord_q;
      ocnt_q <= 17'(cnt_q);
      od_q   <= 1'b0;
    end else if (cmd_i.final_emit) begin
      ot_q   <= tag_q;
      oo_q   <= ord_q;
      ocnt_q <= 17'(cnt_q);
      od_q   <= 1'b1;
      if (berr_q != srsp_pkg::ERR_OK) begin
        ok_q   <= srsp_pkg::KIND_ERR;
        oe_q   <= berr_q;
        os_q   <= '0;
        ost_q  <= '0;
        olen_q <= '0;
        of_q   <= '0;
        ol_q   <= '0;
      end else begin
        ok_q   <= srsp_pkg::KIND_SEG;
        oe_q   <= srsp_pkg::ERR_OK;
        os_q   <= open_shard_q;
        ost_q  <= open_start_q;
        olen_q <= open_len_q;
        of_q   <= open_first_q;
        ol_q   <= open_last_q;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_kind_o  = ok_q;
  assign out_done_o  = od_q;
  assign out_data_o  = {3'b000, ocnt_q, oo_q, ot_q, ol_q, of_q, olen_q, ost_q, os_q, oe_q};

endmodule

FILE: rtl/core/shard_range_segment_planner.sv
// Top level of the shard range segment planner.
// Table items (clear, append): acknowledgement registered once the output is free.
// Batch samples: check, search, end read and compare, merge; the last sample also gets
// a final result; each search step is a read and a compare.
// One item is worked on at a time; a result not yet taken stalls the next result.
// Reset clears all control and batch state; table entries stay undefined until written.
module shard_range_segment_planner #(
  parameter int unsigned MaxShards = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [31:0]  cfg_data_i,     // total_images
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // shard id, range first, range count, sample id, tag, ordinal
  input  logic [191:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,   // req_type
  input  logic         s_axis_tlast,   // last_in_batch
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // error_code, seg_shard, seg_start, seg_length, seg_first_image,
  // seg_last_image, out_tag, out_ordinal, samples_so_far
  output logic [215:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,   // result_kind
  output logic         m_axis_tlast    // batch_done
);

  srsp_pkg::cmd_t cmd;
  srsp_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  srsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srsp_datapath #(
    .MaxShards (MaxShards)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_req_i    (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_data_o  (m_axis_tdata),
    .out_done_o  (m_axis_tlast)
  );

endmodule
